// ===== src/salc_pkg.sv =====
// Package for the set-associative LRU tag cache.
// Holds sizes, command and outcome codes, and the queue entry type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
  localparam int unsigned MaxSetBits = 6;
  localparam int unsigned MaxWays    = 8;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_NONE  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS  = 2'd0,
    CFG_WAYS      = 2'd1,
    CFG_OFFSET    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_e;

  // One access handed from the front end to the back end.
  typedef struct packed {
    logic [63:0] tag;
    logic [11:0] set;
    logic        last;
  } acc_t;

  localparam int unsigned CntW = 32;
endpackage
`default_nettype wire

// ===== src/salc_front.sv =====
// Front end: accepts items, splits addresses into set and tag, and emits one
// access per cycle while the queue takes them (two for modify). Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_front #(
  parameter int unsigned MaxSetBits = salc_pkg::MaxSetBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [63:0]       address_i,
  input  wire logic [2:0]        set_bits_i,
  input  wire logic [5:0]        offset_bits_i,
  output logic                   acc_valid_o,
  input  wire logic              acc_ready_i,
  output salc_pkg::acc_t         acc_o
);
  localparam int unsigned SetW = (MaxSetBits > 0) ? MaxSetBits : 1;

  logic           pend_q, pend_d;
  logic           again_q, again_d;
  salc_pkg::acc_t acc_q, acc_d;
  logic [6:0]     tshift;
  logic [2:0]     sbits;
  logic [63:0]    shifted;
  logic [11:0]    set_mask;

  always_comb begin
    sbits = (32'(set_bits_i) > MaxSetBits) ? 3'(MaxSetBits) : set_bits_i;
    tshift = 7'(offset_bits_i) + 7'(sbits);
    shifted = address_i >> offset_bits_i;
    set_mask = (12'd1 << sbits) - 12'd1;
  end

  assign in_ready_o = !pend_q || (acc_ready_i && !again_q);
  assign acc_valid_o = pend_q;
  assign acc_o = acc_q;

  always_comb begin
    pend_d = pend_q;
    again_d = again_q;
    acc_d = acc_q;
    if (pend_q && acc_ready_i) begin
      if (again_q) begin
        again_d = 1'b0;
        acc_d.last = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (in_valid_i && in_ready_o) begin
      pend_d = 1'b1;
      acc_d.tag = tshift[6] ? 64'd0 : (address_i >> tshift[5:0]);
      acc_d.set = shifted[11:0] & set_mask & 12'((1 << SetW) - 1);
      again_d = (salc_pkg::cmd_e'(command_i) == salc_pkg::CMD_MODIFY);
      acc_d.last = !again_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      again_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      again_q <= again_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  property p_modify_repeats;
    @(posedge clk_i) disable iff (!rst_ni)
      (pend_q && again_q && acc_ready_i) |=> (pend_q && acc_q.last);
  endproperty
  a_modify_repeats: assert property (p_modify_repeats) else $error("second access lost");

  property p_no_take_while_again;
    @(posedge clk_i) disable iff (!rst_ni) again_q |-> !in_ready_o;
  endproperty
  a_no_take_while_again: assert property (p_no_take_while_again) else $error("overrun");

  property p_again_pend;
    @(posedge clk_i) disable iff (!rst_ni) again_q |-> pend_q;
  endproperty
  a_again_pend: assert property (p_again_pend) else $error("again without access");
endmodule
`default_nettype wire

// ===== src/salc_queue.sv =====
// Two-entry queue between front and back end. Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  salc_pkg::acc_t      wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output salc_pkg::acc_t      rd_data_o
);
  salc_pkg::acc_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d = wp_q ^ push;
    rp_d = rp_q ^ pop;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointer mismatch");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("pointer mismatch");
endmodule
`default_nettype wire

// ===== src/salc_back.sv =====
// Back end: per-access set lookup, LRU update and result register.
// Tags in a memory, valid bits and ranks in flip-flops. Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_back #(
  parameter int unsigned MaxSetBits = salc_pkg::MaxSetBits,
  parameter int unsigned MaxWays    = salc_pkg::MaxWays
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           acc_valid_i,
  output logic                acc_ready_o,
  input  salc_pkg::acc_t      acc_i,
  input  wire logic [3:0]     ways_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output logic [1:0]          outcome_o,
  output logic                last_o,
  output logic [31:0]         hit_total_o,
  output logic [31:0]         miss_total_o,
  output logic [31:0]         eviction_total_o
);
  localparam int unsigned NumSets = 1 << MaxSetBits;
  localparam int unsigned SetW = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned RankW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned WayW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam logic [RankW-1:0] RankTop = RankW'(MaxWays - 1);

  typedef enum logic { ST_READ, ST_UPDATE } st_e;

  logic [63:0]      tag_mem [NumSets][MaxWays];
  logic [63:0]      rd_tag_q [MaxWays];
  logic             rd_valid_q [MaxWays];
  logic [RankW-1:0] rd_rank_q [MaxWays];
  logic             valid_q [NumSets][MaxWays];
  logic [RankW-1:0] rank_q [NumSets][MaxWays];
  logic             valid_nx [MaxWays];
  logic [RankW-1:0] rank_nx [MaxWays];

  st_e            st_q, st_d;
  salc_pkg::acc_t cur_q;
  logic [SetW-1:0] set_idx;
  logic [4:0]     nw;
  logic           res_v_q;
  logic [1:0]     outc_q;
  logic           last_q;
  logic [31:0]    hit_q, miss_q, evc_q;

  logic             hit, has_free;
  logic [WayW-1:0]  hit_w, free_w, vic_w, tgt_w;
  logic [RankW-1:0] hit_r, vic_r;
  logic [1:0]       outc;
  logic             do_upd;

  assign set_idx = cur_q.set[SetW-1:0];
  assign nw = (ways_i == 4'd0) ? 5'd1 :
              ((32'(ways_i) > MaxWays) ? 5'(MaxWays) : {1'b0, ways_i});

  // Output register may be refilled as it drains.
  assign do_upd = (st_q == ST_UPDATE) && (!res_v_q || res_ready_i);

  always_comb begin
    acc_ready_o = (st_q == ST_READ);
    st_d = st_q;
    case (st_q)
      ST_READ:   if (acc_valid_i) st_d = ST_UPDATE;
      ST_UPDATE: if (do_upd) st_d = ST_READ;
      default:   st_d = ST_READ;
    endcase
  end

  // The set row (tags, valid bits, ranks) is registered in the read step.
  always_comb begin
    hit = 1'b0; hit_w = '0; hit_r = '0;
    has_free = 1'b0; free_w = '0;
    vic_w = '0; vic_r = rd_rank_q[0];
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (w < nw && rd_valid_q[w] && rd_tag_q[w] == cur_q.tag) begin
        hit = 1'b1; hit_w = WayW'(w); hit_r = rd_rank_q[w];
      end
      if (w < nw && !rd_valid_q[w]) begin
        has_free = 1'b1; free_w = WayW'(w);
      end
    end
    for (int w = 1; w < MaxWays; w++) begin
      if (w < nw && rd_rank_q[w] > vic_r) begin
        vic_r = rd_rank_q[w]; vic_w = WayW'(w);
      end
    end
    outc = hit ? 2'(salc_pkg::OUT_HIT) :
           (has_free ? 2'(salc_pkg::OUT_FILL) : 2'(salc_pkg::OUT_EVICT));
    tgt_w = hit ? hit_w : (has_free ? free_w : vic_w);
  end

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      valid_nx[w] = rd_valid_q[w];
      rank_nx[w] = rd_rank_q[w];
      if (w < nw && WayW'(w) != tgt_w && rd_valid_q[w]) begin
        if ((hit && rd_rank_q[w] < hit_r) ||
            (!hit && has_free && rd_rank_q[w] < RankTop) ||
            (!hit && !has_free && rd_rank_q[w] < vic_r))
          rank_nx[w] = rd_rank_q[w] + 1'b1;
      end
      if (WayW'(w) == tgt_w) begin
        rank_nx[w] = '0;
        valid_nx[w] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_valid_i && st_q == ST_READ) begin
      cur_q <= acc_i;
      for (int w = 0; w < MaxWays; w++) begin
        rd_tag_q[w] <= tag_mem[acc_i.set[SetW-1:0]][w];
        rd_valid_q[w] <= valid_q[acc_i.set[SetW-1:0]][w];
        rd_rank_q[w] <= rank_q[acc_i.set[SetW-1:0]][w];
      end
    end
    if (do_upd && outc != 2'(salc_pkg::OUT_HIT)) tag_mem[set_idx][tgt_w] <= cur_q.tag;
    if (do_upd) begin
      outc_q <= outc;
      last_q <= cur_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_READ;
      res_v_q <= 1'b0;
      hit_q <= '0; miss_q <= '0; evc_q <= '0;
      for (int s = 0; s < NumSets; s++)
        for (int w = 0; w < MaxWays; w++) begin
          valid_q[s][w] <= 1'b0; rank_q[s][w] <= '0;
        end
    end else begin
      st_q <= st_d;
      if (do_upd) res_v_q <= 1'b1;
      else if (res_ready_i) res_v_q <= 1'b0;
      if (do_upd) begin
        if (hit) begin
          if (hit_q != '1) hit_q <= hit_q + 32'd1;
        end else begin
          if (miss_q != '1) miss_q <= miss_q + 32'd1;
          if (!has_free && evc_q != '1) evc_q <= evc_q + 32'd1;
        end
        for (int w = 0; w < MaxWays; w++) begin
          rank_q[set_idx][w] <= rank_nx[w];
          valid_q[set_idx][w] <= valid_nx[w];
        end
      end
    end
  end

  assign res_valid_o = res_v_q;
  assign outcome_o = outc_q;
  assign last_o = last_q;
  assign hit_total_o = hit_q;
  assign miss_total_o = miss_q;
  assign eviction_total_o = evc_q;

  a_upd_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPDATE) |-> $past(st_q == ST_UPDATE || acc_valid_i)) else $error("bad step");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_ready_i) |=> (res_v_q && $stable(outc_q))) else $error("result lost");
  a_outc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> (outc_q != 2'(salc_pkg::OUT_NONE))) else $error("bad outcome");
endmodule
`default_nettype wire

// ===== src/set_assoc_lru_cache_model_unit.sv =====
// Set-associative tag cache with true LRU replacement, top level.
// Path: an accepted access passes the front-end register, the queue, the tag read and the update.
// The back end reads the set of an access, then updates it into the result register, and only then
// takes the next access; a modify item makes two accesses.
// Reset: asynchronous, clears valid bits, ranks and totals and resets the configuration; tags are left as is.
// Uses salc_pkg, salc_front, salc_queue and salc_back.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_model_unit #(
  parameter int unsigned MaxSetBits = salc_pkg::MaxSetBits,
  parameter int unsigned MaxWays    = salc_pkg::MaxWays
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,   // command[1:0], address[65:2], zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // outcome[1:0], hit, miss, eviction totals
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [5:0]   cfg_data_i
);
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd0;
      ways_q <= 4'd1;
      offset_q <= 6'd0;
    end else if (cfg_we_i) begin
      case (salc_pkg::cfg_e'(cfg_idx_i))
        salc_pkg::CFG_SET_BITS: set_bits_q <= cfg_data_i[2:0];
        salc_pkg::CFG_WAYS:     ways_q <= cfg_data_i[3:0];
        salc_pkg::CFG_OFFSET:   offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           f_v, f_r, q_v, q_r;
  salc_pkg::acc_t f_d, q_d;
  logic [1:0]     outcome;
  logic [31:0]    hit_t, miss_t, evc_t;

  salc_front #(.MaxSetBits(MaxSetBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .command_i(s_axis_tdata[1:0]), .address_i(s_axis_tdata[65:2]),
    .set_bits_i(set_bits_q), .offset_bits_i(offset_q),
    .acc_valid_o(f_v), .acc_ready_i(f_r), .acc_o(f_d));

  salc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_v), .wr_ready_o(f_r), .wr_data_i(f_d),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_data_o(q_d));

  salc_back #(.MaxSetBits(MaxSetBits), .MaxWays(MaxWays)) u_back (
    .clk_i, .rst_ni,
    .acc_valid_i(q_v), .acc_ready_o(q_r), .acc_i(q_d), .ways_i(ways_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .outcome_o(outcome), .last_o(m_axis_tlast),
    .hit_total_o(hit_t), .miss_total_o(miss_t), .eviction_total_o(evc_t));

  assign m_axis_tdata = {6'd0, evc_t, miss_t, hit_t, outcome};
endmodule
`default_nettype wire

// ===== test/set_assoc_lru_cache_model_unit_tb.sv =====
// Self-checking testbench for the set-associative LRU tag cache.
// Drives the slave stream and configuration port, checks the master stream against
// a local cache model. Depends on salc_pkg and set_assoc_lru_cache_model_unit.
`timescale 1ns / 1ps

class cache_scoreboard;
  typedef struct {
    salc_pkg::outcome_e outcome;
    logic               last;
    logic [31:0]        hits;
    logic [31:0]        misses;
    logic [31:0]        evicts;
  } cache_result_t;

  logic [63:0]   tag_mem [512];
  bit            valid_mem [512];
  int unsigned   rank_mem [512];
  logic [31:0]   hit_cnt, miss_cnt, evict_cnt;
  int unsigned   set_bits, ways, off_bits;
  cache_result_t expected_q [$];
  int unsigned   errors, results_seen, hits_seen, evicts_seen;

  function new();
    foreach (valid_mem[i]) begin
      valid_mem[i] = 0;
      rank_mem[i]  = 0;
      tag_mem[i]   = '0;
    end
    hit_cnt = 0; miss_cnt = 0; evict_cnt = 0;
    set_bits = 0; ways = 1; off_bits = 0;
    errors = 0; results_seen = 0; hits_seen = 0; evicts_seen = 0;
  endfunction

  function void write_reg(salc_pkg::cfg_e idx, int unsigned val);
    case (idx)
      salc_pkg::CFG_SET_BITS: set_bits = val & 7;
      salc_pkg::CFG_WAYS:     ways     = val & 15;
      salc_pkg::CFG_OFFSET:   off_bits = val & 63;
      default: ;
    endcase
  endfunction

  function logic [31:0] sat(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function salc_pkg::outcome_e lookup(logic [63:0] addr);
    int unsigned sb, nw, tshift, base, victim, vrank, r;
    int          free_way;
    logic [63:0] tag, setv;
    sb = (set_bits > salc_pkg::MaxSetBits) ? salc_pkg::MaxSetBits : set_bits;
    nw = (ways == 0) ? 1 : (ways > salc_pkg::MaxWays) ? salc_pkg::MaxWays : ways;
    tshift = off_bits + sb;
    tag  = (tshift >= 64) ? 64'd0 : addr >> tshift;
    setv = (addr >> off_bits) & ((64'd1 << sb) - 1);
    base = int'(setv) * salc_pkg::MaxWays;
    for (int w = 0; w < nw; w++) begin
      if (valid_mem[base+w] && tag_mem[base+w] == tag) begin
        r = rank_mem[base+w];
        for (int k = 0; k < nw; k++)
          if (k != w && valid_mem[base+k] && rank_mem[base+k] < r) rank_mem[base+k]++;
        rank_mem[base+w] = 0;
        hit_cnt = sat(hit_cnt);
        return salc_pkg::OUT_HIT;
      end
    end
    miss_cnt = sat(miss_cnt);
    free_way = -1;
    for (int w = 0; w < nw; w++)
      if (free_way < 0 && !valid_mem[base+w]) free_way = w;
    if (free_way >= 0) begin
      for (int w = 0; w < nw; w++)
        if (valid_mem[base+w] && rank_mem[base+w] < salc_pkg::MaxWays - 1) rank_mem[base+w]++;
      valid_mem[base+free_way] = 1;
      tag_mem[base+free_way]   = tag;
      rank_mem[base+free_way]  = 0;
      return salc_pkg::OUT_FILL;
    end
    // Evict the way with the highest rank; the lowest way number wins a tie.
    victim = 0;
    vrank  = rank_mem[base];
    for (int w = 1; w < nw; w++)
      if (rank_mem[base+w] > vrank) begin
        vrank  = rank_mem[base+w];
        victim = w;
      end
    for (int w = 0; w < nw; w++)
      if (w != victim && valid_mem[base+w] && rank_mem[base+w] < vrank) rank_mem[base+w]++;
    tag_mem[base+victim]  = tag;
    rank_mem[base+victim] = 0;
    evict_cnt = sat(evict_cnt);
    return salc_pkg::OUT_EVICT;
  endfunction

  function void note_request(salc_pkg::cmd_e cmd, logic [63:0] addr);
    cache_result_t res;
    int unsigned   n;
    n = (cmd == salc_pkg::CMD_MODIFY) ? 2 : 1;
    for (int i = 0; i < n; i++) begin
      res.outcome = lookup(addr);
      res.last    = (i == n - 1);
      res.hits    = hit_cnt;
      res.misses  = miss_cnt;
      res.evicts  = evict_cnt;
      expected_q.insert(expected_q.size(), res);
    end
  endfunction

  function void check_result(logic [103:0] data, logic last);
    cache_result_t exp_r;
    results_seen++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result tdata=%h", data);
      return;
    end
    exp_r = expected_q.pop_front();
    if (exp_r.outcome == salc_pkg::OUT_HIT) hits_seen++;
    if (exp_r.outcome == salc_pkg::OUT_EVICT) evicts_seen++;
    if (data[1:0] !== exp_r.outcome || last !== exp_r.last || data[33:2] !== exp_r.hits ||
        data[65:34] !== exp_r.misses || data[97:66] !== exp_r.evicts) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: expected outcome %0d last %0b totals %0d/%0d/%0d, got %0d %0b %0d/%0d/%0d",
                 exp_r.outcome, exp_r.last, exp_r.hits, exp_r.misses, exp_r.evicts,
                 data[1:0], last, data[33:2], data[65:34], data[97:66]);
    end
  endfunction
endclass

module set_assoc_lru_cache_model_unit_tb;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  wire          s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // command[1:0], address[65:2], zero pad
  wire          m_axis_tvalid;
  logic         m_axis_tready = 0;
  wire  [103:0] m_axis_tdata;        // outcome[1:0], hit[33:2], miss[65:34], eviction[97:66]
  wire          m_axis_tlast;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_idx_i = '0;
  logic [5:0]   cfg_data_i = '0;

  cache_scoreboard sb = new();
  int unsigned idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int unsigned cycles = 0;
  int unsigned requests = 0;

  set_assoc_lru_cache_model_unit uut (.*);

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sink side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    case (idle_mode)
      2:       m_axis_tready <= ($urandom_range(0, 99) >= 75);
      3:       m_axis_tready <= ($urandom_range(0, 99) >= 33);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  function bit sender_idles();
    case (idle_mode)
      1:       return $urandom_range(0, 99) < 75;
      3:       return $urandom_range(0, 99) < 33;
      default: return 0;
    endcase
  endfunction

  task automatic send(salc_pkg::cmd_e cmd, logic [63:0] addr);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, addr, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, addr);
    requests++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned sbits, int unsigned nways, int unsigned obits);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= salc_pkg::CFG_SET_BITS; cfg_data_i <= 6'(sbits);
    @(posedge clk_i);
    cfg_idx_i <= salc_pkg::CFG_WAYS; cfg_data_i <= 6'(nways);
    @(posedge clk_i);
    cfg_idx_i <= salc_pkg::CFG_OFFSET; cfg_data_i <= 6'(obits);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(salc_pkg::CFG_SET_BITS, sbits);
    sb.write_reg(salc_pkg::CFG_WAYS, nways);
    sb.write_reg(salc_pkg::CFG_OFFSET, obits);
  endtask

  // Mostly a few tags per set so that hits and evictions occur; sometimes any address.
  function automatic logic [63:0] pick_address();
    logic [63:0] full, a;
    int unsigned tshift;
    full = {$urandom(), $urandom()};
    if ($urandom_range(0, 7) == 0) return full;
    tshift = sb.off_bits + ((sb.set_bits > salc_pkg::MaxSetBits) ?
                            salc_pkg::MaxSetBits : sb.set_bits);
    a = (64'($urandom_range(0, 9)) << tshift) | (full & ((64'd1 << tshift) - 1));
    if ($urandom_range(0, 15) == 0) a[63] = 1'b1;
    return a;
  endfunction

  function automatic salc_pkg::cmd_e pick_command();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return salc_pkg::CMD_LOAD;
      4, 5, 6:    return salc_pkg::CMD_STORE;
      7, 8:       return salc_pkg::CMD_MODIFY;
      default:    return salc_pkg::CMD_SPARE;
    endcase
  endfunction

  int unsigned cfg_tab [10][3] = '{
    '{4, 8, 6}, '{4, 2, 6}, '{4, 8, 6}, '{7, 15, 63}, '{6, 0, 40},
    '{0, 1, 0}, '{2, 4, 32}, '{6, 8, 5}, '{3, 3, 61}, '{1, 7, 12}};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset configuration: one way, one set, full-address tags.
    send(salc_pkg::CMD_LOAD, 64'd0);
    send(salc_pkg::CMD_STORE, 64'd0);
    send(salc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send(salc_pkg::CMD_SPARE, 64'hAAAA_AAAA_AAAA_AAAA);
    send(salc_pkg::CMD_MODIFY, 64'h5555_5555_5555_5555);
    send(salc_pkg::CMD_LOAD, 64'h5555_5555_5555_5555);
    // Two ways and offsets up to 63: the tag collapses to zero once the shifts pass 64 bits.
    configure(7, 2, 63);
    send(salc_pkg::CMD_LOAD, 64'h8000_0000_0000_0000);
    send(salc_pkg::CMD_STORE, 64'h0000_0000_0000_0001);
    send(salc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    configure(1, 2, 0);
    send(salc_pkg::CMD_LOAD, 64'h0);
    send(salc_pkg::CMD_LOAD, 64'h2);
    send(salc_pkg::CMD_LOAD, 64'h4);
    send(salc_pkg::CMD_LOAD, 64'h0);
    send(salc_pkg::CMD_LOAD, 64'h6);
    send(salc_pkg::CMD_MODIFY, 64'h3);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= salc_pkg::CFG_UNUSED; cfg_data_i <= 6'h3F;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send(salc_pkg::CMD_STORE, 64'h4);

    for (int ph = 0; ph < 10; ph++) begin
      configure(cfg_tab[ph][0], cfg_tab[ph][1], cfg_tab[ph][2]);
      idle_mode = ph % 4;
      for (int i = 0; i < 180; i++) send(pick_command(), pick_address());
    end
    idle_mode = 0;
    drain();

    $display("Sent %0d items over ten cache settings; %0d results checked, %0d hits, %0d evictions.",
             requests, sb.results_seen, sb.hits_seen, sb.evicts_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
